[rtl/b64d_pkg.sv]
// Shared types, constants and the character-to-sextet lookup of the base64 decoder.
package b64d_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LENGTH  = 2'd2
  } status_e;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChPad    = 8'h3D;

  localparam logic [7:0] LowerOffset = 8'd71;
  localparam logic [7:0] DigitOffset = 8'd4;
  localparam logic [5:0] SextetHi62  = 6'd62;
  localparam logic [5:0] SextetHi63  = 6'd63;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  // One decoded result group: up to three bytes, or a single status-only result.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  cnt;
    logic        last;
    logic        stat_only;
    status_e     status;
  } grp_t;

  function automatic sextet_t b64d_sextet(input logic [7:0] c, input logic url);
    sextet_t    s;
    logic [7:0] t;
    s = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
    t = 8'd0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      t = c - ChUpperA;
      s.val = t[5:0];
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      t = c - LowerOffset;
      s.val = t[5:0];
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      t = c + DigitOffset;
      s.val = t[5:0];
    end else if (url && c == ChMinus) begin
      s.val = SextetHi62;
    end else if (url && c == ChUnder) begin
      s.val = SextetHi63;
    end else if (!url && c == ChPlus) begin
      s.val = SextetHi62;
    end else if (!url && c == ChSlash) begin
      s.val = SextetHi63;
    end else if (!url && c == ChPad) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

[rtl/b64d_decode.sv]
// Character decoder: group state, padding and error tracking, result group building.
module b64d_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             url_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_in_i,
  input  logic             last_char_i,
  input  logic             load_ok_i,
  output logic             grp_load_o,
  output b64d_pkg::grp_t   grp_o
);
  import b64d_pkg::*;

  logic        url_q;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  status_e     err_q, err_d, err_n;
  sextet_t     s;
  logic [5:0]  v;
  logic [17:0] grown;
  logic [23:0] word;
  logic [1:0]  nbytes;
  logic        stat_only;
  logic        accept;

  always_comb begin
    s      = b64d_sextet(char_in_i, url_q);
    v      = s.val;
    err_n  = err_q;
    pad_d  = pad_q;
    acc_d  = acc_q;
    pos_d  = pos_q;
    word   = 24'd0;
    nbytes = 2'd0;
    grown  = {acc_q[11:0], v};
    if (err_q == ST_OK) begin
      if (s.bad) begin
        err_n = ST_INVALID;
      end else if (s.pad) begin
        if (pos_q < 2'd2) begin
          err_n = ST_INVALID;
        end else begin
          pad_d = pad_q + 2'd1;
          v = 6'd0;
        end
      end else if (pad_q != 2'd0) begin
        err_n = ST_INVALID;
      end
      grown = {acc_q[11:0], v};
      if (err_n == ST_OK) begin
        if (pos_q == 2'd3) begin
          word = {acc_q, v};
          if (pad_d != 2'd0 && !last_char_i) begin
            err_n = ST_INVALID;
          end else begin
            nbytes = 2'd3 - pad_d;
          end
          acc_d = 18'd0;
          pos_d = 2'd0;
          pad_d = 2'd0;
        end else begin
          if (last_char_i) begin
            if (url_q && pos_q != 2'd0) begin
              word = (pos_q == 2'd1) ? {grown[11:0], 12'h000} : {grown, 6'h00};
              nbytes = pos_q;
            end else begin
              err_n = ST_LENGTH;
            end
          end
          acc_d = grown;
          pos_d = pos_q + 2'd1;
        end
      end
    end
    err_d = err_n;
    if (last_char_i) begin
      acc_d = 18'd0;
      pos_d = 2'd0;
      pad_d = 2'd0;
      err_d = ST_OK;
    end
  end

  assign stat_only = last_char_i && (err_n != ST_OK || nbytes == 2'd0);

  always_comb begin
    grp_o.word      = stat_only ? 24'd0 : word;
    grp_o.cnt       = stat_only ? 2'd1 : nbytes;
    grp_o.last      = last_char_i;
    grp_o.stat_only = stat_only;
    grp_o.status    = stat_only ? err_n : ST_OK;
  end

  assign in_ready_o = (grp_o.cnt == 2'd0) || load_ok_i;
  assign accept     = in_valid_i && in_ready_o;
  assign grp_load_o = accept && (grp_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
      acc_q <= 18'd0;
      pos_q <= 2'd0;
      pad_q <= 2'd0;
      err_q <= ST_OK;
    end else begin
      if (cfg_valid_i) begin
        url_q <= url_mode_i;
      end
      if (accept) begin
        acc_q <= acc_d;
        pos_q <= pos_d;
        pad_q <= pad_d;
        err_q <= err_d;
      end
    end
  end

endmodule

[rtl/b64d_serializer.sv]
// Result group register that hands out one result per cycle on the output channel while the receiver is ready.
module b64d_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             grp_load_i,
  input  b64d_pkg::grp_t   grp_i,
  output logic             load_ok_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic             byte_valid_o,
  output logic             last_out_o,
  output logic [1:0]       status_o
);
  import b64d_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  grp_t       grp_q;
  logic       pop;
  logic       done;

  assign done      = idx_q == (grp_q.cnt - 2'd1);
  assign pop       = valid_q && out_ready_i;
  assign load_ok_o = !valid_q || (pop && done);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (pop) begin
      if (done) begin
        valid_d = 1'b0;
        idx_d   = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (grp_load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_load_i) begin
      grp_q <= grp_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = grp_q.word[23:16];
      2'd1:    data_byte_o = grp_q.word[15:8];
      default: data_byte_o = grp_q.word[7:0];
    endcase
  end

  assign out_valid_o  = valid_q;
  assign byte_valid_o = !grp_q.stat_only;
  assign last_out_o   = grp_q.last && done;
  assign status_o     = grp_q.status;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < grp_q.cnt)
    else $error("Result index beyond the group size.");

  a_status_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && grp_q.stat_only |-> grp_q.last && grp_q.cnt == 2'd1)
    else $error("Status-only group is not a single final result.");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_load_i |-> load_ok_o)
    else $error("Group loaded while the previous one is still pending.");

  a_drain_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && done && !grp_load_i |=> !valid_q)
    else $error("Group register not freed after its final result.");

endmodule

[rtl/base64_url_decoder_top.sv]
// Top level of the streaming base64 and base64url decoder.
//
// The input channel takes one character per request, with last_char_i on the
// final character of a text. The output channel delivers one result per
// request: a decoded byte, or on error a single status-only result that ends
// the text. The configuration channel writes url_mode and is always ready;
// the user must write it only while the decoder is idle; it is not enforced.
// A character is taken every cycle unless it waits for the group register. A
// character that completes a group, or ends the text, loads a result group of
// one to three results that appear on the output in the cycle after acceptance
// and leave one per cycle while the receiver is ready. Characters that produce
// no result keep flowing while a group drains, so four characters per three
// bytes run at full rate. A character that needs the group register waits
// only while that register still holds results. When the receiver stalls, the
// group holds and input stops at the next character that produces results.
// Reset clears the group state, the error and url_mode; the output is empty.
module base64_url_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       url_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_out_o,
  output logic [1:0] status_o
);
  import b64d_pkg::*;

  grp_t grp;
  logic grp_load;
  logic load_ok;

  assign cfg_ready_o = 1'b1;

  b64d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .url_mode_i  (url_mode_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .last_char_i (last_char_i),
    .load_ok_i   (load_ok),
    .grp_load_o  (grp_load),
    .grp_o       (grp)
  );

  b64d_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_load_i   (grp_load),
    .grp_i        (grp),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_out_o   (last_out_o),
    .status_o     (status_o)
  );

endmodule
